[rtl/bols_pkg.sv]
// Package for the bounded ordered list store: opcodes, status codes and the sequencer state type.
// Depends on nothing; the core refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bols_pkg;

	// Opcodes of an input beat.
	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_DUMP      = 3'd1;
	localparam logic [2:0] OP_DEL_FIRST = 3'd2;
	localparam logic [2:0] OP_INS_END   = 3'd3;
	localparam logic [2:0] OP_DEL_LAST  = 3'd4;
	localparam logic [2:0] OP_DEL_POS   = 3'd5;
	localparam logic [2:0] OP_COUNT     = 3'd6;

	// Status codes of a result beat.
	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_EMPTY  = 3'd1;
	localparam logic [2:0] STAT_BADPOS = 3'd2;
	localparam logic [2:0] STAT_BOUNDS = 3'd3;
	localparam logic [2:0] STAT_FULL   = 3'd4;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MV_RD,
		ST_MV_WR,
		ST_DUMP,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

[rtl/bounded_ordered_list_store_core.sv]
// Bounded ordered list store: a circular buffer in one RAM, run by a small sequencer.
// Depends on bols_pkg for opcodes, status codes and the state type.
//
// Channel   Signals                                   Direction  Handshake
// command   start, opcode, item_value, position       in         start & !busy
// result    result_valid, status, entry_value,        out        result_valid, one cycle,
//           entry_count, last                                    cannot be held off
//
// An accepted command keeps busy high through the execute state, so for insert, delete first,
// delete last and count the result shows in the same cycle as busy falls.
// Delete at position P of N entries moves N-P entries through the single RAM port pair,
// each with a read state (ST_MV_RD) followed by a write state (ST_MV_WR).
// A dump streams one entry per cycle behind the registered RAM read, then passes ST_DRAIN.
// Reset clears the entry count and head pointer; the RAM itself is not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_store_core #(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         opcode,
	input  wire logic signed [31:0] item_value,
	input  wire logic [5:0]         position,
	output logic                    result_valid,
	output logic [2:0]              status,
	output logic signed [31:0]      entry_value,
	output logic [5:0]              entry_count,
	output logic                    last
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 6) ? CW : 6;

	// Control and payload registers.
	bols_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] head_q, head_d;
	logic [CW-1:0] j_q, j_d;
	logic [2:0]    op_q;
	logic [31:0]   val_q;
	logic [5:0]    pos_q;
	logic          dmp_v_s1, dmp_v_d;
	logic          dmp_last_s1, dmp_last_d;

	// Memory and its ports.
	logic [31:0]   store_q [CAPACITY];
	logic [31:0]   rd_data_q;
	logic          rd_en, wr_en;
	logic [31:0]   wr_data;

	// Shared address unit.
	logic [CW-1:0] off;
	logic [IW:0]   addr_sum;
	logic [IW:0]   addr_wrap;
	logic [IW-1:0] addr;

	// Result staging.
	logic          res_v;
	logic [2:0]    res_stat;
	logic [31:0]   res_val;
	logic          res_last;
	logic          result_valid_q;
	logic [2:0]    status_q;
	logic [31:0]   entry_value_q;
	logic [5:0]    entry_count_q;
	logic          last_q;

	logic          accept;
	logic [CW-1:0] j_inc;
	logic          full, empty;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] count_ext;
	logic [PW-1:0] pos_m1;

	assign accept    = start & ~busy;
	assign busy      = (state_q != bols_pkg::ST_IDLE);
	assign j_inc     = j_q + CW'(1);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_ext   = PW'(pos_q);
	assign count_ext = PW'(count_q);
	assign pos_m1    = pos_ext - PW'(1);

	// Logical offset to physical RAM index, wrapped once around the buffer.
	always_comb begin
		addr_sum  = {1'b0, head_q} + (IW + 1)'(off);
		addr_wrap = (addr_sum >= (IW + 1)'(CAPACITY)) ? addr_sum - (IW + 1)'(CAPACITY)
			: addr_sum;
		addr      = addr_wrap[IW-1:0];
	end

	// Sequencer: next state, address unit control, RAM strobes and result staging.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		head_d     = head_q;
		j_d        = j_q;
		off        = '0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_data    = val_q;
		dmp_v_d    = 1'b0;
		dmp_last_d = 1'b0;
		res_v      = 1'b0;
		res_stat   = bols_pkg::STAT_OK;
		res_val    = '0;
		res_last   = 1'b1;

		case (state_q)
			bols_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = bols_pkg::ST_EXEC;
				end
			end
			bols_pkg::ST_EXEC: begin
				state_d = bols_pkg::ST_IDLE;
				res_v   = 1'b1;
				case (op_q)
					bols_pkg::OP_INS_FRONT: begin
						if (full) begin
							res_stat = bols_pkg::STAT_FULL;
						end else begin
							off     = CW'(CAPACITY - 1);
							wr_en   = 1'b1;
							head_d  = addr;
							count_d = count_q + CW'(1);
						end
					end
					bols_pkg::OP_DUMP: begin
						if (empty) begin
							res_stat = bols_pkg::STAT_EMPTY;
						end else begin
							res_v   = 1'b0;
							j_d     = '0;
							state_d = bols_pkg::ST_DUMP;
						end
					end
					bols_pkg::OP_DEL_FIRST: begin
						if (empty) begin
							res_stat = bols_pkg::STAT_EMPTY;
						end else begin
							off     = CW'(1);
							head_d  = addr;
							count_d = count_q - CW'(1);
						end
					end
					bols_pkg::OP_INS_END: begin
						if (full) begin
							res_stat = bols_pkg::STAT_FULL;
						end else begin
							off     = count_q;
							wr_en   = 1'b1;
							count_d = count_q + CW'(1);
						end
					end
					bols_pkg::OP_DEL_LAST: begin
						if (empty) begin
							res_stat = bols_pkg::STAT_EMPTY;
						end else begin
							count_d = count_q - CW'(1);
						end
					end
					bols_pkg::OP_DEL_POS: begin
						if (empty) begin
							res_stat = bols_pkg::STAT_EMPTY;
						end else if (pos_q == '0) begin
							res_stat = bols_pkg::STAT_BADPOS;
						end else if (pos_ext > count_ext) begin
							res_stat = bols_pkg::STAT_BOUNDS;
						end else begin
							res_v   = 1'b0;
							j_d     = CW'(pos_m1);
							state_d = bols_pkg::ST_MV_RD;
						end
					end
					default: begin
						res_stat = bols_pkg::STAT_OK;
					end
				endcase
			end
			// Close the gap: fetch the entry behind the hole.
			bols_pkg::ST_MV_RD: begin
				if (j_inc < count_q) begin
					off     = j_inc;
					rd_en   = 1'b1;
					state_d = bols_pkg::ST_MV_WR;
				end else begin
					count_d = count_q - CW'(1);
					res_v   = 1'b1;
					state_d = bols_pkg::ST_IDLE;
				end
			end
			// Write the fetched entry one place toward the front.
			bols_pkg::ST_MV_WR: begin
				off     = j_q;
				wr_en   = 1'b1;
				wr_data = rd_data_q;
				j_d     = j_inc;
				state_d = bols_pkg::ST_MV_RD;
			end
			bols_pkg::ST_DUMP: begin
				off        = j_q;
				rd_en      = 1'b1;
				dmp_v_d    = 1'b1;
				dmp_last_d = (j_inc == count_q);
				j_d        = j_inc;
				if (j_inc == count_q) begin
					state_d = bols_pkg::ST_DRAIN;
				end
			end
			bols_pkg::ST_DRAIN: begin
				state_d = bols_pkg::ST_IDLE;
			end
			default: begin
				state_d = bols_pkg::ST_IDLE;
			end
		endcase

		// A dump beat leaves the RAM read register in the cycle after its read.
		if (dmp_v_s1) begin
			res_v    = 1'b1;
			res_stat = bols_pkg::STAT_OK;
			res_val  = rd_data_q;
			res_last = dmp_last_s1;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bols_pkg::ST_IDLE;
			count_q        <= '0;
			head_q         <= '0;
			j_q            <= '0;
			dmp_v_s1       <= 1'b0;
			dmp_last_s1    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			count_q        <= count_d;
			head_q         <= head_d;
			j_q            <= j_d;
			dmp_v_s1       <= dmp_v_d;
			dmp_last_s1    <= dmp_last_d;
			result_valid_q <= res_v;
		end
	end

	// Command capture and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			val_q <= item_value;
			pos_q <= position;
		end
		if (res_v) begin
			status_q      <= res_stat;
			entry_value_q <= res_val;
			entry_count_q <= 6'(count_d);
			last_q        <= res_last;
		end
	end

	// Entry RAM: one port addressed by the shared unit, registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= store_q[addr];
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign entry_value  = signed'(entry_value_q);
	assign entry_count  = entry_count_q;
	assign last         = last_q;

	// The list never holds more than its capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The head pointer stays inside the buffer.
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IW'(CAPACITY - 1))
		else $error("head pointer outside the buffer");

	// A pending dump beat never outlives busy.
	a_dump_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !dmp_v_s1)
		else $error("dump beat pending while idle");

	// Dump beats stream without gaps until the last one.
	a_dump_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> result_valid)
		else $error("gap inside a dump stream");

	// An accepted command always occupies the sequencer.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted without going busy");

endmodule

`default_nettype wire
